>>> hdl/sgb_pkg.sv
// Shared types, constants and arithmetic helpers of the separable Gaussian blur.
package sgb_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_RADIUS = 4;
	localparam int WIN_LEN    = 2 * MAX_RADIUS + 1;
	// The line store keeps one row more than the window, because the next row starts
	// filling while the outputs at the end of the current row are still pending.
	localparam int ROW_SLOTS  = WIN_LEN + 1;
	localparam int PIX_W      = 16;
	localparam int COEF_W     = 16;
	localparam int COL_W      = 10;
	localparam int DIM_W      = 11;
	localparam int RAD_W      = 3;
	localparam int SLOT_W     = 4;
	localparam int ADDR_W     = SLOT_W + COL_W;
	localparam int RAM_DEPTH  = ROW_SLOTS * MAX_WIDTH;
	localparam int ACC_W      = PIX_W + COEF_W + 4;
	localparam int TAP_REGS   = 5;
	localparam int TAP_IDX_W  = 3;
	localparam int CNT_W      = 4;
	localparam int POS_W      = 12;
	localparam int PADDR_W    = 5;
	localparam int PDATA_W    = 32;

	typedef enum logic [2:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_RADIUS = 3'd2,
		REG_TAP0   = 3'd3,
		REG_TAP1   = 3'd4,
		REG_TAP2   = 3'd5,
		REG_TAP3   = 3'd6,
		REG_TAP4   = 3'd7
	} reg_idx_t;

	typedef enum logic [0:0] {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	// Effective frame geometry and kernel, already clamped to legal ranges.
	typedef struct packed {
		logic [DIM_W-1:0]               width;
		logic [DIM_W-1:0]               height;
		logic [RAD_W-1:0]               radius;
		logic [TAP_REGS-1:0][COEF_W-1:0] taps;
	} cfg_t;

	// Shift commands for the column result chain.
	typedef struct packed {
		logic load;
		logic back;
	} cell_ctrl_t;

	// Rounds half up, drops the fraction bits and saturates to the pixel range.
	function automatic logic [PIX_W-1:0] round_sat(input logic [ACC_W-1:0] acc);
		logic [ACC_W:0]        sum;
		logic [ACC_W-COEF_W:0] shifted;
		sum     = {1'b0, acc} + (ACC_W+1)'(1 << (COEF_W - 1));
		shifted = sum[ACC_W:COEF_W];
		if (shifted > (ACC_W-COEF_W+1)'({PIX_W{1'b1}})) begin
			return {PIX_W{1'b1}};
		end
		return shifted[PIX_W-1:0];
	endfunction

	// Distance between a counter position and the window center.
	function automatic logic [TAP_IDX_W-1:0] tap_dist(input logic [CNT_W-1:0] pos,
			input logic [RAD_W-1:0] rad);
		logic [CNT_W-1:0] r_ext;
		logic [CNT_W-1:0] d;
		r_ext = CNT_W'(rad);
		d = (pos >= r_ext) ? (pos - r_ext) : (r_ext - pos);
		return d[TAP_IDX_W-1:0];
	endfunction

endpackage

>>> hdl/sgb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module sgb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hdl/sgb_cell.sv
// One cell of the column result chain; shifts forward on load and backward on read-out.
module sgb_cell (
	input  logic                     clk,
	input  sgb_pkg::cell_ctrl_t      ctrl,
	input  logic [sgb_pkg::PIX_W-1:0] from_left,
	input  logic [sgb_pkg::PIX_W-1:0] from_right,
	output logic [sgb_pkg::PIX_W-1:0] value
);

	logic [sgb_pkg::PIX_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			value_q <= from_left;
		end else if (ctrl.back) begin
			value_q <= from_right;
		end
	end

	assign value = value_q;

endmodule

>>> hdl/sgb_regs.sv
// Configuration registers behind the APB-style port, with clamped effective values.
module sgb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sgb_pkg::PADDR_W-1:0] paddr,
	input  logic [sgb_pkg::PDATA_W-1:0] pwdata,
	output logic [sgb_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output sgb_pkg::cfg_t               cfg
);

	logic [sgb_pkg::DIM_W-1:0]  width_q;
	logic [sgb_pkg::DIM_W-1:0]  height_q;
	logic [sgb_pkg::RAD_W-1:0]  radius_q;
	logic [sgb_pkg::TAP_REGS-1:0][sgb_pkg::COEF_W-1:0] taps_q;
	sgb_pkg::reg_idx_t          idx;
	logic                       wr;

	assign pready = 1'b1;
	assign idx    = sgb_pkg::reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sgb_pkg::DIM_W'(1024);
			height_q <= sgb_pkg::DIM_W'(1024);
			radius_q <= sgb_pkg::RAD_W'(1);
			// Only the center tap is nonzero after reset.
			taps_q   <= (sgb_pkg::TAP_REGS*sgb_pkg::COEF_W)'({sgb_pkg::COEF_W{1'b1}});
		end else if (wr) begin
			unique case (idx)
				sgb_pkg::REG_WIDTH:  width_q   <= pwdata[sgb_pkg::DIM_W-1:0];
				sgb_pkg::REG_HEIGHT: height_q  <= pwdata[sgb_pkg::DIM_W-1:0];
				sgb_pkg::REG_RADIUS: radius_q  <= pwdata[sgb_pkg::RAD_W-1:0];
				sgb_pkg::REG_TAP0:   taps_q[0] <= pwdata[sgb_pkg::COEF_W-1:0];
				sgb_pkg::REG_TAP1:   taps_q[1] <= pwdata[sgb_pkg::COEF_W-1:0];
				sgb_pkg::REG_TAP2:   taps_q[2] <= pwdata[sgb_pkg::COEF_W-1:0];
				sgb_pkg::REG_TAP3:   taps_q[3] <= pwdata[sgb_pkg::COEF_W-1:0];
				sgb_pkg::REG_TAP4:   taps_q[4] <= pwdata[sgb_pkg::COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			sgb_pkg::REG_WIDTH:  prdata = sgb_pkg::PDATA_W'(width_q);
			sgb_pkg::REG_HEIGHT: prdata = sgb_pkg::PDATA_W'(height_q);
			sgb_pkg::REG_RADIUS: prdata = sgb_pkg::PDATA_W'(radius_q);
			sgb_pkg::REG_TAP0:   prdata = sgb_pkg::PDATA_W'(taps_q[0]);
			sgb_pkg::REG_TAP1:   prdata = sgb_pkg::PDATA_W'(taps_q[1]);
			sgb_pkg::REG_TAP2:   prdata = sgb_pkg::PDATA_W'(taps_q[2]);
			sgb_pkg::REG_TAP3:   prdata = sgb_pkg::PDATA_W'(taps_q[3]);
			sgb_pkg::REG_TAP4:   prdata = sgb_pkg::PDATA_W'(taps_q[4]);
			default: ;
		endcase
	end

	always_comb begin
		cfg.taps = taps_q;
		if (width_q == '0) begin
			cfg.width = sgb_pkg::DIM_W'(1);
		end else if (width_q > sgb_pkg::DIM_W'(sgb_pkg::MAX_WIDTH)) begin
			cfg.width = sgb_pkg::DIM_W'(sgb_pkg::MAX_WIDTH);
		end else begin
			cfg.width = width_q;
		end
		if (height_q == '0) begin
			cfg.height = sgb_pkg::DIM_W'(1);
		end else if (height_q > sgb_pkg::DIM_W'(sgb_pkg::MAX_HEIGHT)) begin
			cfg.height = sgb_pkg::DIM_W'(sgb_pkg::MAX_HEIGHT);
		end else begin
			cfg.height = height_q;
		end
		cfg.radius = (radius_q > sgb_pkg::RAD_W'(sgb_pkg::MAX_RADIUS)) ?
			sgb_pkg::RAD_W'(sgb_pkg::MAX_RADIUS) : radius_q;
	end

endmodule

>>> hdl/separable_gaussian_blur.sv
// Top level of the streaming separable Gaussian blur with clamp-to-edge borders.
//
// Usage: pixels enter in raster order as input transactions (op = pixel) on the
// in_valid / in_stall channel; drain transactions (op = drain) flush the outputs that
// remain after the last pixel. Each input transaction yields at most one output
// transaction on out_valid / out_stall, in raster order, with frame_end set on the
// last pixel of the frame. Outputs start once radius rows plus radius + 1 pixels have
// arrived. The block works on one transaction at a time, with its pace set by the
// single read port of the line store and the single multiply-accumulate unit that
// serves both passes. The column pass results travel through a chain of nine cells
// that feeds the row pass.
// The result sits in an output register, so the next input transaction is taken
// while the previous result waits; if the receiver keeps stalling, the block holds
// its finished result and raises in_stall until the register frees up.
// Reset returns the positions to the start of a frame and loads the default
// kernel registers; the line store holds no defined data until it is written.
// Configuration is to be written over the APB-style port only while no transaction
// is in work; the block itself does not enforce this.
module separable_gaussian_blur (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        op,
	input  logic [sgb_pkg::PIX_W-1:0]   pixel_in,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [sgb_pkg::PIX_W-1:0]   pixel_out,
	output logic                        frame_end,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sgb_pkg::PADDR_W-1:0] paddr,
	input  logic [sgb_pkg::PDATA_W-1:0] pwdata,
	output logic [sgb_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_CHECK   = 9'b000000010,
		S_RD      = 9'b000000100,
		S_MUL     = 9'b000001000,
		S_ACC     = 9'b000010000,
		S_COL     = 9'b000100000,
		S_ROW_MUL = 9'b001000000,
		S_ROW_ACC = 9'b010000000,
		S_DONE    = 9'b100000000
	} state_t;

	sgb_pkg::cfg_t cfg;

	sgb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	state_t                       state_q;
	// Input and output positions; slots are row numbers modulo the stored row count.
	logic [sgb_pkg::COL_W-1:0]    in_col_q;
	logic [sgb_pkg::DIM_W-1:0]    in_row_q;
	logic [sgb_pkg::SLOT_W-1:0]   in_slot_q;
	logic [sgb_pkg::COL_W-1:0]    out_col_q;
	logic [sgb_pkg::COL_W-1:0]    out_row_q;
	logic [sgb_pkg::SLOT_W-1:0]   out_slot_q;
	// Window walk: column counter, row counter and read-out counter.
	logic [sgb_pkg::CNT_W-1:0]    kc_q;
	logic [sgb_pkg::CNT_W-1:0]    jc_q;
	logic [sgb_pkg::POS_W-1:0]    u_q;
	logic [sgb_pkg::POS_W-1:0]    v_q;
	logic [sgb_pkg::COL_W-1:0]    cy_q;
	logic [sgb_pkg::SLOT_W-1:0]   slot_q;
	logic [sgb_pkg::ACC_W-1:0]    acc_q;
	logic [2*sgb_pkg::PIX_W-1:0]  prod_q;
	logic                         out_valid_q;
	logic [sgb_pkg::PIX_W-1:0]    pixel_out_q;
	logic                         frame_end_q;

	logic                         accept;
	logic                         store_pixel;
	logic [sgb_pkg::COL_W-1:0]    w_m1;
	logic [sgb_pkg::COL_W-1:0]    h_m1;
	logic [sgb_pkg::CNT_W-1:0]    span_m1;
	logic [sgb_pkg::DIM_W-1:0]    need_row;
	logic [sgb_pkg::DIM_W-1:0]    need_col;
	logic                         ready;
	logic [sgb_pkg::COL_W-1:0]    cx;
	logic [sgb_pkg::ADDR_W-1:0]   raddr;
	logic [sgb_pkg::ADDR_W-1:0]   waddr;
	logic [sgb_pkg::PIX_W-1:0]    rdata;
	logic [sgb_pkg::POS_W-1:0]    v_start;
	logic [sgb_pkg::COL_W-1:0]    cy_start;
	logic [sgb_pkg::SLOT_W-1:0]   slot_start;
	logic [sgb_pkg::SLOT_W+1-1:0] slot_tmp;
	logic [sgb_pkg::POS_W-1:0]    v_next;
	logic                         last;
	logic                         out_free;
	logic [sgb_pkg::COEF_W-1:0]   col_wt;
	logic [sgb_pkg::COEF_W-1:0]   row_wt;
	logic [sgb_pkg::PIX_W-1:0]    col_result;
	sgb_pkg::cell_ctrl_t          cell_ctrl;
	logic [sgb_pkg::PIX_W-1:0]    cell_val [sgb_pkg::WIN_LEN];

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;
	assign frame_end = frame_end_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign w_m1    = sgb_pkg::COL_W'(cfg.width - sgb_pkg::DIM_W'(1));
	assign h_m1    = sgb_pkg::COL_W'(cfg.height - sgb_pkg::DIM_W'(1));
	assign span_m1 = {cfg.radius, 1'b0};

	assign store_pixel = accept && (sgb_pkg::op_t'(op) == sgb_pkg::OP_PIXEL) &&
		(in_row_q < cfg.height);

	// Readiness: every input pixel of the next output's clamped window is stored.
	always_comb begin
		need_row = sgb_pkg::DIM_W'(out_row_q) + sgb_pkg::DIM_W'(cfg.radius);
		if (need_row > sgb_pkg::DIM_W'(h_m1)) begin
			need_row = sgb_pkg::DIM_W'(h_m1);
		end
		need_col = sgb_pkg::DIM_W'(out_col_q) + sgb_pkg::DIM_W'(cfg.radius);
		if (need_col > sgb_pkg::DIM_W'(w_m1)) begin
			need_col = sgb_pkg::DIM_W'(w_m1);
		end
		ready = (in_row_q > need_row) ||
			((in_row_q == need_row) && (sgb_pkg::DIM_W'(in_col_q) > need_col));
	end

	// Clamped column of the current window column.
	always_comb begin
		if (u_q[sgb_pkg::POS_W-1]) begin
			cx = '0;
		end else if (u_q > sgb_pkg::POS_W'(w_m1)) begin
			cx = w_m1;
		end else begin
			cx = u_q[sgb_pkg::COL_W-1:0];
		end
	end

	// Start of the vertical walk: first row clamped to the top edge.
	always_comb begin
		v_start  = sgb_pkg::POS_W'(out_row_q) - sgb_pkg::POS_W'(cfg.radius);
		slot_tmp = sgb_pkg::SLOT_W'(out_slot_q) + (sgb_pkg::SLOT_W+1)'(sgb_pkg::ROW_SLOTS)
			- (sgb_pkg::SLOT_W+1)'(cfg.radius);
		if (slot_tmp >= (sgb_pkg::SLOT_W+1)'(sgb_pkg::ROW_SLOTS)) begin
			slot_tmp = slot_tmp - (sgb_pkg::SLOT_W+1)'(sgb_pkg::ROW_SLOTS);
		end
		if (v_start[sgb_pkg::POS_W-1]) begin
			cy_start   = '0;
			slot_start = '0;
		end else begin
			cy_start   = v_start[sgb_pkg::COL_W-1:0];
			slot_start = slot_tmp[sgb_pkg::SLOT_W-1:0];
		end
	end

	assign v_next = v_q + sgb_pkg::POS_W'(1);
	assign raddr  = {slot_q, cx};
	assign waddr  = {in_slot_q, in_col_q};
	assign col_wt = cfg.taps[sgb_pkg::tap_dist(jc_q, cfg.radius)];
	assign row_wt = cfg.taps[sgb_pkg::tap_dist(kc_q, cfg.radius)];
	assign col_result = sgb_pkg::round_sat(acc_q);
	assign last = (sgb_pkg::DIM_W'(out_col_q) + sgb_pkg::DIM_W'(1) >= cfg.width) &&
		(sgb_pkg::DIM_W'(out_row_q) + sgb_pkg::DIM_W'(1) >= cfg.height);

	sgb_ram #(
		.WIDTH (sgb_pkg::PIX_W),
		.DEPTH (sgb_pkg::RAM_DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (store_pixel),
		.waddr (waddr),
		.wdata (pixel_in),
		.raddr (raddr),
		.rdata (rdata)
	);

	// The chain loads column results at cell 0 and shifts them back toward cell 0
	// during the row pass; the symmetric kernel makes the read-out order irrelevant.
	assign cell_ctrl.load = (state_q == S_COL);
	assign cell_ctrl.back = (state_q == S_ROW_MUL);

	for (genvar i = 0; i < sgb_pkg::WIN_LEN; i++) begin : g_chain
		logic [sgb_pkg::PIX_W-1:0] left_in;
		logic [sgb_pkg::PIX_W-1:0] right_in;
		if (i == 0) begin : g_head
			assign left_in = col_result;
		end else begin : g_mid
			assign left_in = cell_val[i-1];
		end
		if (i == sgb_pkg::WIN_LEN - 1) begin : g_tail
			assign right_in = '0;
		end else begin : g_body
			assign right_in = cell_val[i+1];
		end
		sgb_cell u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl),
			.from_left  (left_in),
			.from_right (right_in),
			.value      (cell_val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_col_q    <= '0;
			in_row_q    <= '0;
			in_slot_q   <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_slot_q  <= '0;
			kc_q        <= '0;
			jc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A taken result frees the register unless a new one is loaded below.
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CHECK;
					end
					if (store_pixel) begin
						if (sgb_pkg::DIM_W'(in_col_q) + sgb_pkg::DIM_W'(1) >= cfg.width) begin
							in_col_q <= '0;
							in_row_q <= in_row_q + sgb_pkg::DIM_W'(1);
							in_slot_q <= (in_slot_q == sgb_pkg::SLOT_W'(sgb_pkg::ROW_SLOTS - 1)) ?
								'0 : in_slot_q + sgb_pkg::SLOT_W'(1);
						end else begin
							in_col_q <= in_col_q + sgb_pkg::COL_W'(1);
						end
					end
				end
				S_CHECK: begin
					kc_q    <= '0;
					jc_q    <= '0;
					state_q <= ready ? S_RD : S_IDLE;
				end
				S_RD: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (jc_q == span_m1) begin
						state_q <= S_COL;
					end else begin
						jc_q    <= jc_q + sgb_pkg::CNT_W'(1);
						state_q <= S_RD;
					end
				end
				S_COL: begin
					jc_q <= '0;
					if (kc_q == span_m1) begin
						kc_q    <= '0;
						state_q <= S_ROW_MUL;
					end else begin
						kc_q    <= kc_q + sgb_pkg::CNT_W'(1);
						state_q <= S_RD;
					end
				end
				S_ROW_MUL: begin
					state_q <= S_ROW_ACC;
				end
				S_ROW_ACC: begin
					if (kc_q == span_m1) begin
						state_q <= S_DONE;
					end else begin
						kc_q    <= kc_q + sgb_pkg::CNT_W'(1);
						state_q <= S_ROW_MUL;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (last) begin
							in_col_q   <= '0;
							in_row_q   <= '0;
							in_slot_q  <= '0;
							out_col_q  <= '0;
							out_row_q  <= '0;
							out_slot_q <= '0;
						end else if (sgb_pkg::DIM_W'(out_col_q) + sgb_pkg::DIM_W'(1) >=
								cfg.width) begin
							out_col_q  <= '0;
							out_row_q  <= out_row_q + sgb_pkg::COL_W'(1);
							out_slot_q <= (out_slot_q == sgb_pkg::SLOT_W'(sgb_pkg::ROW_SLOTS - 1)) ?
								'0 : out_slot_q + sgb_pkg::SLOT_W'(1);
						end else begin
							out_col_q <= out_col_q + sgb_pkg::COL_W'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers: window walk positions, product and accumulator.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_CHECK: begin
				u_q    <= sgb_pkg::POS_W'(out_col_q) - sgb_pkg::POS_W'(cfg.radius);
				v_q    <= v_start;
				cy_q   <= cy_start;
				slot_q <= slot_start;
				acc_q  <= '0;
			end
			S_MUL: begin
				prod_q <= rdata * col_wt;
			end
			S_ACC: begin
				acc_q <= acc_q + sgb_pkg::ACC_W'(prod_q);
				v_q   <= v_next;
				// Step down one row unless still above the top edge or at the bottom.
				if (!v_next[sgb_pkg::POS_W-1] && (v_next != '0) && (cy_q != h_m1)) begin
					cy_q   <= cy_q + sgb_pkg::COL_W'(1);
					slot_q <= (slot_q == sgb_pkg::SLOT_W'(sgb_pkg::ROW_SLOTS - 1)) ?
						'0 : slot_q + sgb_pkg::SLOT_W'(1);
				end
			end
			S_COL: begin
				u_q    <= u_q + sgb_pkg::POS_W'(1);
				v_q    <= v_start;
				cy_q   <= cy_start;
				slot_q <= slot_start;
				acc_q  <= '0;
			end
			S_ROW_MUL: begin
				prod_q <= cell_val[0] * row_wt;
			end
			S_ROW_ACC: begin
				acc_q <= acc_q + sgb_pkg::ACC_W'(prod_q);
			end
			S_DONE: begin
				if (out_free) begin
					pixel_out_q <= col_result;
					frame_end_q <= last;
				end
			end
			default: ;
		endcase
	end

endmodule
